// ----- rtl/lps_pkg.sv -----
package lps_pkg;

  localparam int LED_W        = 3;
  localparam int NOW_W        = 32;
  localparam int STEP_IDX_W   = 3;
  localparam int STEP_IN_W    = 16;
  localparam int STEP_TIME_W  = 14;
  localparam int STEP_SLOTS   = 8;
  localparam int PERIOD_W     = 16;
  localparam int DIVIDEND_W   = 32;
  localparam int DIVISOR_W    = 17;
  localparam int DIV_CNT_W    = 6;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [STEP_IN_W-1:0] STEP_MIN_MS   = 16'd20;
  localparam logic [STEP_IN_W-1:0] STEP_MAX_MS   = 16'd10000;
  localparam logic [PERIOD_W-1:0]  FAST_FLOOR_MS = 16'd40;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS     = 6'd32;

  localparam logic [1:0] SPEED_SLOW = 2'd1;
  localparam logic [1:0] SPEED_FAST = 2'd3;

  localparam logic [2:0] MODE_STEADY    = 3'd0;
  localparam logic [2:0] MODE_BLINK     = 3'd1;
  localparam logic [2:0] MODE_ALTERNATE = 3'd2;
  localparam logic [2:0] MODE_CHASE     = 3'd3;
  localparam logic [2:0] MODE_PAIR      = 3'd4;
  localparam logic [2:0] MODE_CUSTOM    = 3'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_MODE   = 3'd0,
    CFG_BASE_MASK      = 3'd1,
    CFG_BASE_PERIOD    = 3'd2,
    CFG_SPEED_LEVEL    = 3'd3,
    CFG_OUTPUTS_ENABLE = 3'd4,
    CFG_STEP_COUNT     = 3'd5,
    CFG_SEQ_START      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 q_lsb;
    logic [1:0]           q_mod3;
    logic [DIVISOR_W-1:0] rem;
  } div_res_t;

endpackage

// ----- rtl/lps_req_if.sv -----
interface lps_req_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [lps_pkg::NOW_W-1:0]        now_ms;
  logic [lps_pkg::STEP_IDX_W-1:0]   step_index;
  logic [lps_pkg::LED_W-1:0]        step_mask;
  logic [lps_pkg::STEP_IN_W-1:0]    step_time_ms;

  modport source (output valid, kind, now_ms, step_index, step_mask, step_time_ms,
                  input ready);
  modport sink (input valid, kind, now_ms, step_index, step_mask, step_time_ms,
                output ready);
endinterface

// ----- rtl/lps_rsp_if.sv -----
interface lps_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lps_pkg::LED_W-1:0] led_mask;

  modport source (output valid, led_mask, input ready);
  modport sink (input valid, led_mask, output ready);
endinterface

// ----- rtl/led_pattern_sequencer_unit.sv -----
// LED pattern sequencer.
// The req channel carries one item per transfer. A time sample (kind 0) yields
// one led_mask transfer on the rsp channel; a step write (kind 1) stores one
// custom step, with its duration clamped to 20..10000 ms, and yields nothing.
// Configuration registers are written through cfg_we, cfg_index and cfg_data,
// one register per cycle; the user must write them only while no item is in
// flight, as the block does not enforce this. A step write leaves the input
// ready. A time sample for a built-in pattern is reduced by a bit-serial
// divider; in custom mode with steps loaded the step durations are summed one
// per cycle, the time is reduced by the divider and the steps are walked one
// per cycle. With outputs disabled or no custom steps the result skips the
// divider. The divider, which retires one quotient bit per cycle, sets the rate.
// One item is processed at a time; the result sits in an output register, so
// the next item is taken while an earlier result waits for the receiver.
// A stalled receiver holds the finished result until the output register frees.
// Reset restores the configuration defaults and empties the output register.
// The step table is not cleared and must be loaded before custom mode is used.
module led_pattern_sequencer_unit #(
  parameter int MAX_STEPS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  lps_req_if.sink                        req,
  lps_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [lps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lps_pkg::*;

  localparam int DEPTH = (MAX_STEPS < STEP_SLOTS) ? MAX_STEPS : STEP_SLOTS;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [3:0] DEPTH_N = 4'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_DIV  = 5'b00100,
    S_WALK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [2:0]            pattern_mode;
  logic [LED_W-1:0]      base_mask;
  logic [PERIOD_W-1:0]   base_period;
  logic [1:0]            speed_level;
  logic                  outputs_enabled;
  logic [3:0]            step_count;
  logic [NOW_W-1:0]      seq_start;

  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  div_d;
  logic                  div_start;
  logic [DIVISOR_W-1:0]  elapsed;
  logic [3:0]            walk_idx;
  logic [LED_W-1:0]      res_mask;
  logic                  out_valid;
  logic [LED_W-1:0]      out_mask;

  logic [3:0]            n_eff;
  logic                  last_step;
  logic [PERIOD_W-1:0]   half;
  logic [PERIOD_W-1:0]   scaled;
  logic [PERIOD_W-1:0]   period;
  logic [DIVISOR_W-1:0]  sum_next;
  logic                  accept;
  logic                  step_wr;
  logic                  custom;
  logic [LED_W-1:0]      rd_mask;
  logic [STEP_TIME_W-1:0] rd_time;
  div_req_t              div_req;
  div_res_t              div_res;

  function automatic logic [LED_W-1:0] builtin_mask(input logic [2:0] mode,
                                                    input logic [LED_W-1:0] base,
                                                    input logic q_lsb,
                                                    input logic [1:0] q3);
    logic [LED_W-1:0] bit_sel;
    logic [LED_W-1:0] m;
    bit_sel = LED_W'(1) << q3;
    unique case (mode)
      MODE_BLINK:     m = q_lsb ? '0 : base;
      MODE_ALTERNATE: m = q_lsb ? (base & 3'b010) : (base & 3'b101);
      MODE_CHASE:     m = ((base & bit_sel) != '0) ? bit_sel : base;
      MODE_PAIR: begin
        unique case (q3)
          2'd0:    m = base & 3'b011;
          2'd1:    m = base & 3'b110;
          default: m = base & 3'b101;
        endcase
      end
      default:        m = base;
    endcase
    return m;
  endfunction

  lps_steps #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_steps (
    .clk      (clk),
    .wr_en    (step_wr),
    .wr_index (req.step_index),
    .wr_mask  (req.step_mask),
    .wr_time  (req.step_time_ms),
    .rd_index (walk_idx[IDX_W-1:0]),
    .rd_mask  (rd_mask),
    .rd_time  (rd_time)
  );

  lps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = dvd;
  assign div_req.divisor  = div_d;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign step_wr      = accept && req.kind;
  assign custom       = (pattern_mode == MODE_CUSTOM);
  assign rsp.valid    = out_valid;
  assign rsp.led_mask = out_mask;

  always_comb begin
    n_eff     = (step_count > DEPTH_N) ? DEPTH_N : step_count;
    last_step = (walk_idx == (n_eff - 4'd1));
    sum_next  = div_d + DIVISOR_W'(rd_time);
    half      = {1'b0, base_period[PERIOD_W-1:1]};
    unique case (speed_level)
      SPEED_SLOW: scaled = {base_period[PERIOD_W-2:0], 1'b0};
      SPEED_FAST: scaled = (half < FAST_FLOOR_MS) ? FAST_FLOOR_MS : half;
      default:    scaled = base_period;
    endcase
    period = (scaled == '0) ? PERIOD_W'(1) : scaled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      div_start       <= 1'b0;
      pattern_mode    <= MODE_CHASE;
      base_mask       <= 3'd7;
      base_period     <= 16'd2000;
      speed_level     <= 2'd2;
      outputs_enabled <= 1'b1;
      step_count      <= 4'd0;
      seq_start       <= '0;
    end else begin
      div_start <= (accept && !req.kind && outputs_enabled && !custom) ||
                   ((state == S_SUM) && last_step && (sum_next != '0));

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PATTERN_MODE:   pattern_mode    <= cfg_data[2:0];
          CFG_BASE_MASK:      base_mask       <= cfg_data[LED_W-1:0];
          CFG_BASE_PERIOD:    base_period     <= cfg_data[PERIOD_W-1:0];
          CFG_SPEED_LEVEL:    speed_level     <= cfg_data[1:0];
          CFG_OUTPUTS_ENABLE: outputs_enabled <= cfg_data[0];
          CFG_STEP_COUNT:     step_count      <= cfg_data[3:0];
          CFG_SEQ_START:      seq_start       <= cfg_data[NOW_W-1:0];
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && !req.kind) begin
            dvd <= custom ? (req.now_ms - seq_start) : req.now_ms;
            priority if (!outputs_enabled) begin
              res_mask <= '0;
              state    <= S_DONE;
            end else if (custom) begin
              if (n_eff == 4'd0) begin
                res_mask <= '0;
                state    <= S_DONE;
              end else begin
                walk_idx <= 4'd0;
                div_d    <= '0;
                state    <= S_SUM;
              end
            end else begin
              div_d     <= {1'b0, period};
              state     <= S_DIV;
            end
          end
        end
        S_SUM: begin
          div_d    <= sum_next;
          if (last_step) begin
            walk_idx <= 4'd0;
            if (sum_next == '0) begin
              res_mask <= '0;
              state    <= S_DONE;
            end else begin
              state     <= S_DIV;
            end
          end else begin
            walk_idx <= walk_idx + 4'd1;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            if (custom) begin
              elapsed  <= div_res.rem;
              walk_idx <= 4'd0;
              state    <= S_WALK;
            end else begin
              res_mask <= builtin_mask(pattern_mode, base_mask, div_res.q_lsb,
                                       div_res.q_mod3);
              state    <= S_DONE;
            end
          end
        end
        S_WALK: begin
          if ((elapsed < DIVISOR_W'(rd_time)) || last_step) begin
            res_mask <= rd_mask;
            state    <= S_DONE;
          end else begin
            elapsed  <= elapsed - DIVISOR_W'(rd_time);
            walk_idx <= walk_idx + 4'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_mask  <= res_mask;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/lps_div.sv -----
module lps_div (
  input  logic              clk,
  input  logic              rst,
  input  lps_pkg::div_req_t req,
  output lps_pkg::div_res_t res
);
  import lps_pkg::*;

  logic [DIVIDEND_W-1:0] dvd;
  logic [DIVISOR_W-1:0]  d;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  q_lsb;
  logic [1:0]            q3;
  logic [1:0]            q3_next;
  logic                  done;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [2:0]            q3_wide;

  always_comb begin
    trial    = {rem, dvd[DIVIDEND_W-1]};
    ge       = (trial >= {1'b0, d});
    rem_next = ge ? DIVISOR_W'(trial - {1'b0, d}) : trial[DIVISOR_W-1:0];
    q3_wide  = {q3, 1'b0} + {2'b00, ge};
    q3_next  = (q3_wide >= 3'd3) ? 2'(q3_wide - 3'd3) : q3_wide[1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        dvd   <= req.dividend;
        d     <= req.divisor;
        rem   <= '0;
        q_lsb <= 1'b0;
        q3    <= 2'd0;
        cnt   <= DIV_STEPS;
        done  <= 1'b0;
      end else if (cnt != '0) begin
        dvd   <= {dvd[DIVIDEND_W-2:0], 1'b0};
        rem   <= rem_next;
        q_lsb <= ge;
        q3    <= q3_next;
        cnt   <= cnt - 1'b1;
        done  <= (cnt == DIV_CNT_W'(1));
      end else begin
        done  <= 1'b0;
      end
    end
  end

  assign res.done   = done;
  assign res.q_lsb  = q_lsb;
  assign res.q_mod3 = q3;
  assign res.rem    = rem;
endmodule

// ----- rtl/lps_steps.sv -----
module lps_steps #(
  parameter int DEPTH = 8,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [lps_pkg::STEP_IDX_W-1:0]    wr_index,
  input  logic [lps_pkg::LED_W-1:0]         wr_mask,
  input  logic [lps_pkg::STEP_IN_W-1:0]     wr_time,
  input  logic [IDX_W-1:0]                  rd_index,
  output logic [lps_pkg::LED_W-1:0]         rd_mask,
  output logic [lps_pkg::STEP_TIME_W-1:0]   rd_time
);
  import lps_pkg::*;

  localparam logic [STEP_IDX_W:0] DEPTH_N = (STEP_IDX_W + 1)'(DEPTH);

  logic [LED_W-1:0]       mask_mem [DEPTH];
  logic [STEP_TIME_W-1:0] time_mem [DEPTH];
  logic [STEP_IN_W-1:0]   clamped;

  always_comb begin
    priority if (wr_time < STEP_MIN_MS) begin
      clamped = STEP_MIN_MS;
    end else if (wr_time > STEP_MAX_MS) begin
      clamped = STEP_MAX_MS;
    end else begin
      clamped = wr_time;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, wr_index} < DEPTH_N)) begin
      mask_mem[wr_index[IDX_W-1:0]] <= wr_mask;
      time_mem[wr_index[IDX_W-1:0]] <= clamped[STEP_TIME_W-1:0];
    end
  end

  assign rd_mask = mask_mem[rd_index];
  assign rd_time = time_mem[rd_index];
endmodule

// ----- rtl/lps_checker.sv -----
module lps_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      req_kind,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [lps_pkg::LED_W-1:0] rsp_led_mask
);

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !req_kind) |=> !req_ready)
    else $error("Input still ready right after a time sample transfer.");

  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_kind) |=> req_ready)
    else $error("Step write left the input not ready.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Result valid right after reset.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("Result dropped while stalled.");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> $stable(rsp_led_mask))
    else $error("Result changed while stalled.");

endmodule

bind led_pattern_sequencer_unit lps_checker u_lps_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_kind     (req.kind),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_led_mask (rsp.led_mask)
);
